@@ rtl/bcu_pkg.sv @@
`timescale 1ns / 1ps

package bcu_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register widths.
	localparam int ARITY_W = 2;
	localparam int MASK_W  = 4;
	localparam int POLY_W  = 16;

	// Number of qubit words that feed the map, and monomials of the phase polynomials.
	localparam int NUM_SRC = 4;
	localparam int NUM_MONO = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_ARITY   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_X0 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_Z0 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_X1 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MASK_Z1 = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_POLY_LO = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_POLY_HI = 3'd6;

	// Arity code for a two-qubit map; every other code acts on one qubit.
	localparam logic [ARITY_W-1:0] ARITY_TWO = 2'd2;

	// Reset values of the registers.
	localparam logic [ARITY_W-1:0] ARITY_RST   = 2'd1;
	localparam logic [MASK_W-1:0]  MASK_X0_RST = 4'd1;
	localparam logic [MASK_W-1:0]  MASK_Z0_RST = 4'd2;
	localparam logic [MASK_W-1:0]  MASK_X1_RST = 4'd4;
	localparam logic [MASK_W-1:0]  MASK_Z1_RST = 4'd8;
	localparam logic [POLY_W-1:0]  POLY_RST    = 16'd0;

	// Configuration registers as a group.
	typedef struct packed {
		logic [ARITY_W-1:0] arity;
		logic [MASK_W-1:0]  mask_x0;
		logic [MASK_W-1:0]  mask_z0;
		logic [MASK_W-1:0]  mask_x1;
		logic [MASK_W-1:0]  mask_z1;
		logic [POLY_W-1:0]  poly_lo;
		logic [POLY_W-1:0]  poly_hi;
	} cfg_t;

endpackage

@@ rtl/bcu_in_if.sv @@
`timescale 1ns / 1ps

// Input channel: one word of Pauli frames and phases per beat.
interface bcu_in_if #(
	parameter int WORD_BITS = 64
) ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] first_x;
	logic [WORD_BITS-1:0] first_z;
	logic [WORD_BITS-1:0] second_x;
	logic [WORD_BITS-1:0] second_z;
	logic [WORD_BITS-1:0] phase_lo_in;
	logic [WORD_BITS-1:0] phase_hi_in;
	logic                 last_in;

	modport source (
		output valid, first_x, first_z, second_x, second_z,
		       phase_lo_in, phase_hi_in, last_in,
		input  ready
	);

	modport sink (
		input  valid, first_x, first_z, second_x, second_z,
		       phase_lo_in, phase_hi_in, last_in,
		output ready
	);
endinterface

@@ rtl/bcu_out_if.sv @@
`timescale 1ns / 1ps

// Output channel: one updated word of frames and phases per beat.
interface bcu_out_if #(
	parameter int WORD_BITS = 64
) ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] new_first_x;
	logic [WORD_BITS-1:0] new_first_z;
	logic [WORD_BITS-1:0] new_second_x;
	logic [WORD_BITS-1:0] new_second_z;
	logic [WORD_BITS-1:0] phase_lo_out;
	logic [WORD_BITS-1:0] phase_hi_out;
	logic                 last_out;

	modport source (
		output valid, new_first_x, new_first_z, new_second_x, new_second_z,
		       phase_lo_out, phase_hi_out, last_out,
		input  ready
	);

	modport sink (
		input  valid, new_first_x, new_first_z, new_second_x, new_second_z,
		       phase_lo_out, phase_hi_out, last_out,
		output ready
	);
endinterface

@@ rtl/bitsliced_clifford_update.sv @@
`timescale 1ns / 1ps

// Applies a configured one- or two-qubit Clifford map to WORD_BITS bit-sliced Pauli frames
// per beat. Each new x or z word is the XOR of the input words picked by its 4-bit mask
// (bit 0 first_x, bit 1 first_z, bit 2 second_x, bit 3 second_z); the two phase deltas are
// 16-term ANF polynomials over the same words, added to the mod-4 phase with the carry of
// the low bit going into the high bit. With arity other than two the second qubit enters
// the map as zero and its words pass through unchanged. The block takes one word every
// cycle while the output is not stalled; each word passes through the input register and
// then the result register. A stalled output holds both stages, and in_ch.ready follows
// out_ch.ready combinationally when both stages are full. Configuration is written
// through cfg_we, cfg_index and cfg_data and must only change while no word is in flight.
module bitsliced_clifford_update
	import bcu_pkg::*;
#(
	parameter int WORD_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bcu_in_if.sink                 in_ch,
	bcu_out_if.source              out_ch
);

	cfg_t cfg_q;

	// Input register stage.
	logic                 valid_s1;
	logic [WORD_BITS-1:0] x0_s1, z0_s1, x1_s1, z1_s1, plo_s1, phi_s1;
	logic                 last_s1;

	// Result register stage.
	logic                 valid_s2;
	logic [WORD_BITS-1:0] x0_s2, z0_s2, x1_s2, z1_s2, plo_s2, phi_s2;
	logic                 last_s2;

	logic advance_s2;
	logic advance_s1;

	// Combinational map results.
	logic                 two_qubit;
	logic [WORD_BITS-1:0] src [NUM_SRC];
	logic [WORD_BITS-1:0] term [NUM_MONO];
	logic [WORD_BITS-1:0] dlo, dhi;
	logic [WORD_BITS-1:0] sel_x0, sel_z0, sel_x1, sel_z1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arity   <= ARITY_RST;
			cfg_q.mask_x0 <= MASK_X0_RST;
			cfg_q.mask_z0 <= MASK_Z0_RST;
			cfg_q.mask_x1 <= MASK_X1_RST;
			cfg_q.mask_z1 <= MASK_Z1_RST;
			cfg_q.poly_lo <= POLY_RST;
			cfg_q.poly_hi <= POLY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARITY:   cfg_q.arity   <= cfg_data[ARITY_W-1:0];
				REG_MASK_X0: cfg_q.mask_x0 <= cfg_data[MASK_W-1:0];
				REG_MASK_Z0: cfg_q.mask_z0 <= cfg_data[MASK_W-1:0];
				REG_MASK_X1: cfg_q.mask_x1 <= cfg_data[MASK_W-1:0];
				REG_MASK_Z1: cfg_q.mask_z1 <= cfg_data[MASK_W-1:0];
				REG_POLY_LO: cfg_q.poly_lo <= cfg_data[POLY_W-1:0];
				REG_POLY_HI: cfg_q.poly_hi <= cfg_data[POLY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A stage moves forward when the stage after it is empty or draining.
	assign advance_s2  = !valid_s2 || out_ch.ready;
	assign advance_s1  = !valid_s1 || advance_s2;
	assign in_ch.ready = advance_s1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (advance_s1 && in_ch.valid) begin
			x0_s1   <= in_ch.first_x;
			z0_s1   <= in_ch.first_z;
			x1_s1   <= in_ch.second_x;
			z1_s1   <= in_ch.second_z;
			plo_s1  <= in_ch.phase_lo_in;
			phi_s1  <= in_ch.phase_hi_in;
			last_s1 <= in_ch.last_in;
		end
	end

	// Map inputs: the second qubit is zero unless the map acts on two qubits.
	always_comb begin
		two_qubit = (cfg_q.arity == ARITY_TWO);
		src[0]    = x0_s1;
		src[1]    = z0_s1;
		src[2]    = two_qubit ? x1_s1 : '0;
		src[3]    = two_qubit ? z1_s1 : '0;
	end

	// Monomial words: the AND of the inputs named by each monomial's bits.
	always_comb begin
		for (int m = 0; m < NUM_MONO; m++) begin
			term[m] = '1;
			for (int i = 0; i < NUM_SRC; i++) begin
				if (m[i]) begin
					term[m] = term[m] & src[i];
				end
			end
		end
	end

	// Phase deltas and masked XORs of the inputs.
	always_comb begin
		dlo    = '0;
		dhi    = '0;
		sel_x0 = '0;
		sel_z0 = '0;
		sel_x1 = '0;
		sel_z1 = '0;
		for (int m = 0; m < NUM_MONO; m++) begin
			if (cfg_q.poly_lo[m]) begin
				dlo = dlo ^ term[m];
			end
			if (cfg_q.poly_hi[m]) begin
				dhi = dhi ^ term[m];
			end
		end
		for (int i = 0; i < NUM_SRC; i++) begin
			if (cfg_q.mask_x0[i]) begin
				sel_x0 = sel_x0 ^ src[i];
			end
			if (cfg_q.mask_z0[i]) begin
				sel_z0 = sel_z0 ^ src[i];
			end
			if (cfg_q.mask_x1[i]) begin
				sel_x1 = sel_x1 ^ src[i];
			end
			if (cfg_q.mask_z1[i]) begin
				sel_z1 = sel_z1 ^ src[i];
			end
		end
	end

	// Result register payload; the phase sum carries the low bit into the high bit.
	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			x0_s2   <= sel_x0;
			z0_s2   <= sel_z0;
			x1_s2   <= two_qubit ? sel_x1 : x1_s1;
			z1_s2   <= two_qubit ? sel_z1 : z1_s1;
			plo_s2  <= plo_s1 ^ dlo;
			phi_s2  <= phi_s1 ^ dhi ^ (plo_s1 & dlo);
			last_s2 <= last_s1;
		end
	end

	// Output beat.
	assign out_ch.valid        = valid_s2;
	assign out_ch.new_first_x  = x0_s2;
	assign out_ch.new_first_z  = z0_s2;
	assign out_ch.new_second_x = x1_s2;
	assign out_ch.new_second_z = z1_s2;
	assign out_ch.phase_lo_out = plo_s2;
	assign out_ch.phase_hi_out = phi_s2;
	assign out_ch.last_out     = last_s2;

endmodule
